FILE: rtl/core/xtea_pkg.sv
// ----------------------------------------------------------------------------
// XTEA package
// Shared constants, payload types and the round mixing function.
// ----------------------------------------------------------------------------
package xtea_pkg;

	localparam int unsigned WORD_W = 32;
	localparam int unsigned KEY_WORDS = 4;
	localparam int unsigned KEY_IDX_W = 2;
	localparam int unsigned APB_ADDR_W = 4;
	localparam int unsigned APB_DATA_W = 32;
	localparam logic [WORD_W-1:0] XTEA_DELTA = 32'h9E37_79B9;

	localparam logic ACT_ENCRYPT = 1'b0;
	localparam logic ACT_DECRYPT = 1'b1;

	typedef logic [WORD_W-1:0] word_t;

	typedef struct packed {
		logic  action;
		word_t left_w;
		word_t right_w;
	} blk_t;

	function automatic word_t xtea_mix(input word_t v);
		return ((v << 4) ^ (v >> 5)) + v;
	endfunction

endpackage

FILE: rtl/core/xtea_in_if.sv
// ----------------------------------------------------------------------------
// XTEA input channel
// Valid/ready channel that carries the action and the two block halves.
// ----------------------------------------------------------------------------
interface xtea_in_if;
	logic                 valid;
	logic                 ready;
	logic                 action;
	xtea_pkg::word_t      left_in;
	xtea_pkg::word_t      right_in;

	modport source (output valid, action, left_in, right_in, input ready);
	modport sink   (input valid, action, left_in, right_in, output ready);
endinterface

FILE: rtl/core/xtea_out_if.sv
// ----------------------------------------------------------------------------
// XTEA output channel
// Valid/ready channel that carries the two result halves.
// ----------------------------------------------------------------------------
interface xtea_out_if;
	logic                 valid;
	logic                 ready;
	xtea_pkg::word_t      left_out;
	xtea_pkg::word_t      right_out;

	modport source (output valid, left_out, right_out, input ready);
	modport sink   (input valid, left_out, right_out, output ready);
endinterface

FILE: rtl/core/xtea_block_cipher.sv
// ----------------------------------------------------------------------------
// XTEA block cipher
// Pipelined XTEA encrypt/decrypt of 64-bit blocks under a 128-bit key.
// ----------------------------------------------------------------------------
// One 64-bit block is accepted per clock while the pipe advances, and each
// block carries its own encrypt/decrypt selector, so both directions mix
// freely in the pipeline. Every Feistel half-round has its own register
// stage, and a full pipeline delivers one block per cycle while its results
// are taken. The whole pipe advances only when the output register is empty
// or its result is taken; while a result waits, every stage holds, empty
// ones included, and the input stalls. The four key words are written over
// APB at byte addresses 0, 4, 8 and 12 and must only change while no block
// is in flight.
module xtea_block_cipher #(
	parameter int unsigned ROUNDS = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [xtea_pkg::APB_ADDR_W-1:0]     paddr,
	input  logic [xtea_pkg::APB_DATA_W-1:0]     pwdata,
	output logic [xtea_pkg::APB_DATA_W-1:0]     prdata,
	output logic                                pready,
	xtea_in_if.sink                             in_ch,
	xtea_out_if.source                          out_ch
);

	localparam int unsigned STAGES = 2 * ROUNDS;

	xtea_pkg::word_t key_q [xtea_pkg::KEY_WORDS];
	xtea_pkg::blk_t  pipe_s [STAGES];
	logic            valid_s [STAGES];
	xtea_pkg::blk_t  stage_in [STAGES];
	xtea_pkg::blk_t  stage_out [STAGES];
	logic            advance;

	logic [xtea_pkg::KEY_IDX_W-1:0] reg_idx;
	assign reg_idx = paddr[xtea_pkg::KEY_IDX_W+1:2];

	assign pready = 1'b1;
	assign prdata = key_q[reg_idx];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < int'(xtea_pkg::KEY_WORDS); i++) begin
				key_q[i] <= '0;
			end
		end else if (psel && penable && pwrite && pready) begin
			key_q[reg_idx] <= pwdata;
		end
	end

	assign advance     = !valid_s[STAGES-1] || out_ch.ready;
	assign in_ch.ready = advance;

	assign stage_in[0] = '{action: in_ch.action, left_w: in_ch.left_in,
	                       right_w: in_ch.right_in};

	for (genvar k = 0; k < STAGES; k++) begin : g_stage
		localparam logic [63:0] ENC_PROD = 64'(xtea_pkg::XTEA_DELTA) * 64'((k + 1) / 2);
		localparam logic [63:0] DEC_PROD =
			64'(xtea_pkg::XTEA_DELTA) * 64'(ROUNDS - (k + 1) / 2);
		localparam xtea_pkg::word_t ENC_SUM = ENC_PROD[31:0];
		localparam xtea_pkg::word_t DEC_SUM = DEC_PROD[31:0];
		localparam logic EVEN = ((k % 2) == 0);

		logic                            on_left;
		xtea_pkg::word_t                 src_w;
		xtea_pkg::word_t                 tgt_w;
		xtea_pkg::word_t                 sum_w;
		logic [xtea_pkg::KEY_IDX_W-1:0]  kidx;
		xtea_pkg::word_t                 ksum;
		xtea_pkg::word_t                 f_w;
		xtea_pkg::word_t                 new_w;

		if (k > 0) begin : g_link
			assign stage_in[k] = pipe_s[k-1];
		end

		always_comb begin
			on_left = EVEN ? (stage_in[k].action == xtea_pkg::ACT_ENCRYPT)
			               : (stage_in[k].action == xtea_pkg::ACT_DECRYPT);
			src_w   = on_left ? stage_in[k].right_w : stage_in[k].left_w;
			tgt_w   = on_left ? stage_in[k].left_w : stage_in[k].right_w;
			sum_w   = (stage_in[k].action == xtea_pkg::ACT_DECRYPT) ? DEC_SUM : ENC_SUM;
			kidx    = on_left ? sum_w[1:0] : sum_w[12:11];
			ksum    = sum_w + key_q[kidx];
			f_w     = xtea_pkg::xtea_mix(src_w) ^ ksum;
			new_w   = (stage_in[k].action == xtea_pkg::ACT_DECRYPT) ? (tgt_w - f_w)
			                                                        : (tgt_w + f_w);
			stage_out[k] = stage_in[k];
			if (on_left) begin
				stage_out[k].left_w = new_w;
			end else begin
				stage_out[k].right_w = new_w;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k] <= 1'b0;
			end else if (advance) begin
				valid_s[k] <= (k == 0) ? in_ch.valid : valid_s[(k == 0) ? 0 : k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (advance) begin
				pipe_s[k] <= stage_out[k];
			end
		end
	end

	assign out_ch.valid     = valid_s[STAGES-1];
	assign out_ch.left_out  = pipe_s[STAGES-1].left_w;
	assign out_ch.right_out = pipe_s[STAGES-1].right_w;

endmodule

FILE: rtl/core/xtea_checker.sv
// ----------------------------------------------------------------------------
// XTEA port checker
// Checks handshake behavior seen at the ports of the XTEA block cipher.
// ----------------------------------------------------------------------------
module xtea_checker (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_ready,
	input  logic                    out_valid,
	input  logic                    out_ready,
	input  xtea_pkg::word_t         out_left,
	input  xtea_pkg::word_t         out_right
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("output valid dropped before transfer");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_left) && $stable(out_right))
		else $error("output payload changed while stalled");

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output register");

	a_drain_ready: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready |-> in_ready)
		else $error("input stalled while output drains");

endmodule

bind xtea_block_cipher xtea_checker u_xtea_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (in_ch.ready),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.out_left  (out_ch.left_out),
	.out_right (out_ch.right_out)
);

FILE: bench/tb.sv
// ----------------------------------------------------------------------------
// XTEA block cipher testbench
// Checks encrypt and decrypt results against an in-bench XTEA model
// under several key settings. Key words are loaded and read back over APB
// while the pipeline is empty. Blocks then stream through valid/ready
// channels with random gaps, random output stalls and one long output
// hold-off.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned ROUNDS = 32;
	localparam int ADDR_W = xtea_pkg::APB_ADDR_W;
	localparam int KEY_ADDR_STEP = 4;
	localparam int PHASE_COUNT = 5;
	localparam int BLOCKS_PER_PHASE = 400;
	localparam int HOLD_AFTER = 500;
	localparam int HOLD_CYCLES = 300;
	localparam int NUM_DIRECTED = 16;

	typedef struct packed {
		xtea_pkg::word_t left_w;
		xtea_pkg::word_t right_w;
	} cipher_out_t;

	localparam xtea_pkg::blk_t DIRECTED_BLOCKS [NUM_DIRECTED] = '{
		'{xtea_pkg::ACT_ENCRYPT, 32'h0000_0000, 32'h0000_0000},
		'{xtea_pkg::ACT_DECRYPT, 32'h0000_0000, 32'h0000_0000},
		'{xtea_pkg::ACT_ENCRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
		'{xtea_pkg::ACT_DECRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
		'{xtea_pkg::ACT_ENCRYPT, 32'hFFFF_FFFF, 32'h0000_0000},
		'{xtea_pkg::ACT_DECRYPT, 32'h0000_0000, 32'hFFFF_FFFF},
		'{xtea_pkg::ACT_ENCRYPT, 32'h8000_0000, 32'h0000_0001},
		'{xtea_pkg::ACT_DECRYPT, 32'h0000_0001, 32'h8000_0000},
		'{xtea_pkg::ACT_ENCRYPT, 32'hAAAA_AAAA, 32'h5555_5555},
		'{xtea_pkg::ACT_DECRYPT, 32'h5555_5555, 32'hAAAA_AAAA},
		'{xtea_pkg::ACT_ENCRYPT, 32'h0000_FFFF, 32'hFFFF_0000},
		'{xtea_pkg::ACT_DECRYPT, 32'hFFFF_0000, 32'h0000_FFFF},
		'{xtea_pkg::ACT_ENCRYPT, 32'h0123_4567, 32'h89AB_CDEF},
		'{xtea_pkg::ACT_DECRYPT, 32'h89AB_CDEF, 32'h0123_4567},
		'{xtea_pkg::ACT_ENCRYPT, 32'h7FFF_FFFF, 32'hFFFF_FFFE},
		'{xtea_pkg::ACT_DECRYPT, 32'hFFFF_FFFE, 32'h7FFF_FFFF}
	};

	logic                              clk;
	logic                              arst_n;
	logic                              psel;
	logic                              penable;
	logic                              pwrite;
	logic [ADDR_W-1:0]                 paddr;
	logic [xtea_pkg::APB_DATA_W-1:0]   pwdata;
	logic [xtea_pkg::APB_DATA_W-1:0]   prdata;
	logic                              pready;

	xtea_in_if  in_ch ();
	xtea_out_if out_ch ();

	xtea_block_cipher #(.ROUNDS(ROUNDS)) u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.in_ch   (in_ch),
		.out_ch  (out_ch)
	);

	xtea_pkg::word_t key_words [xtea_pkg::KEY_WORDS];
	cipher_out_t     pending_blocks [$];
	int              fail_count = 0;
	int              blocks_sent = 0;
	int              results_seen = 0;
	int              hold_left = 0;
	bit              hold_done = 1'b0;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#4_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	task automatic note_fail(input string msg);
		fail_count++;
		if (fail_count <= 10) begin
			$display("%0t: %s", $time, msg);
		end
	endtask

	function automatic xtea_pkg::word_t round_mix(input xtea_pkg::word_t v);
		return ((v << 4) ^ (v >> 5)) + v;
	endfunction

	function automatic cipher_out_t xtea_predict(input logic act,
			input xtea_pkg::word_t lw_in, input xtea_pkg::word_t rw_in);
		xtea_pkg::word_t lw;
		xtea_pkg::word_t rw;
		xtea_pkg::word_t sum;
		lw = lw_in;
		rw = rw_in;
		if (act == xtea_pkg::ACT_ENCRYPT) begin
			sum = '0;
			for (int n = 0; n < ROUNDS; n++) begin
				lw = lw + (round_mix(rw) ^ (sum + key_words[sum[1:0]]));
				sum = sum + xtea_pkg::XTEA_DELTA;
				rw = rw + (round_mix(lw) ^ (sum + key_words[sum[12:11]]));
			end
		end else begin
			sum = xtea_pkg::XTEA_DELTA * ROUNDS;
			for (int n = 0; n < ROUNDS; n++) begin
				rw = rw - (round_mix(lw) ^ (sum + key_words[sum[12:11]]));
				sum = sum - xtea_pkg::XTEA_DELTA;
				lw = lw - (round_mix(rw) ^ (sum + key_words[sum[1:0]]));
			end
		end
		return '{left_w: lw, right_w: rw};
	endfunction

	function automatic xtea_pkg::word_t rand_word();
		int pick;
		pick = $urandom_range(99);
		if (pick < 8) begin
			return '0;
		end else if (pick < 16) begin
			return '1;
		end else if (pick < 22) begin
			return xtea_pkg::word_t'(1) << $urandom_range(xtea_pkg::WORD_W - 1);
		end
		return $urandom;
	endfunction

	task automatic apb_write(input int idx, input xtea_pkg::word_t value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_W'(idx * KEY_ADDR_STEP);
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		key_words[idx] = value;
		@(posedge clk);
	endtask

	task automatic check_key_regs();
		for (int idx = 0; idx < xtea_pkg::KEY_WORDS; idx++) begin
			psel <= 1'b1;
			penable <= 1'b0;
			pwrite <= 1'b0;
			paddr <= ADDR_W'(idx * KEY_ADDR_STEP);
			@(posedge clk);
			penable <= 1'b1;
			@(posedge clk);
			while (!pready) @(posedge clk);
			if (prdata !== key_words[idx]) begin
				note_fail($sformatf("key word %0d readback: expected %08h got %08h",
					idx, key_words[idx], prdata));
			end
			psel <= 1'b0;
			penable <= 1'b0;
			@(posedge clk);
		end
	endtask

	task automatic send_block(input logic act, input xtea_pkg::word_t lw,
			input xtea_pkg::word_t rw, input cipher_out_t exp_out);
		while ((blocks_sent < 800 || blocks_sent >= 1200) && $urandom_range(99) < 10) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.action <= act;
		in_ch.left_in <= lw;
		in_ch.right_in <= rw;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		pending_blocks.push_back(exp_out);
		blocks_sent++;
	endtask

	task automatic drain_pipeline();
		in_ch.valid <= 1'b0;
		do @(posedge clk); while (pending_blocks.size() != 0);
	endtask

	task automatic check_block();
		cipher_out_t exp_out;
		results_seen++;
		if (pending_blocks.size() == 0) begin
			note_fail($sformatf("result %08h %08h with nothing pending",
				out_ch.left_out, out_ch.right_out));
		end else begin
			exp_out = pending_blocks.pop_front();
			if (out_ch.left_out !== exp_out.left_w) begin
				note_fail($sformatf("left_out: expected %08h got %08h",
					exp_out.left_w, out_ch.left_out));
			end
			if (out_ch.right_out !== exp_out.right_w) begin
				note_fail($sformatf("right_out: expected %08h got %08h",
					exp_out.right_w, out_ch.right_out));
			end
		end
	endtask

	// output side: check transfers, stall at random, hold off once for a long stretch
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				check_block();
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ch.ready <= 1'b0;
			end else if (!hold_done && results_seen >= HOLD_AFTER) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES - 1;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= !((results_seen < 1300 || results_seen >= 1700) &&
					$urandom_range(99) < 10);
			end
		end
	end

	initial begin
		logic            act;
		xtea_pkg::word_t lw;
		xtea_pkg::word_t rw;
		xtea_pkg::word_t kw;
		cipher_out_t     exp_out;
		cipher_out_t     last_out;
		logic            last_act;
		bit              have_last;

		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		in_ch.valid <= 1'b0;
		in_ch.action <= xtea_pkg::ACT_ENCRYPT;
		in_ch.left_in <= '0;
		in_ch.right_in <= '0;
		for (int idx = 0; idx < xtea_pkg::KEY_WORDS; idx++) key_words[idx] = '0;
		have_last = 1'b0;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset key of all zeros, never written
		check_key_regs();
		for (int i = 0; i < NUM_DIRECTED; i++) begin
			send_block(DIRECTED_BLOCKS[i].action, DIRECTED_BLOCKS[i].left_w,
				DIRECTED_BLOCKS[i].right_w,
				xtea_predict(DIRECTED_BLOCKS[i].action, DIRECTED_BLOCKS[i].left_w,
					DIRECTED_BLOCKS[i].right_w));
		end
		drain_pipeline();

		for (int phase = 0; phase < PHASE_COUNT; phase++) begin
			for (int idx = 0; idx < xtea_pkg::KEY_WORDS; idx++) begin
				case (phase)
					0: kw = '1;
					2: kw = idx[0] ? '1 : '0;
					default: kw = rand_word();
				endcase
				apb_write(idx, kw);
			end
			check_key_regs();
			have_last = 1'b0;

			for (int i = 0; i < BLOCKS_PER_PHASE; i++) begin
				// feed the previous result back in the other direction
				if (have_last && $urandom_range(99) < 25) begin
					act = ~last_act;
					lw = last_out.left_w;
					rw = last_out.right_w;
				end else begin
					act = 1'($urandom_range(1));
					lw = rand_word();
					rw = rand_word();
				end
				exp_out = xtea_predict(act, lw, rw);
				send_block(act, lw, rw, exp_out);
				last_out = exp_out;
				last_act = act;
				have_last = 1'b1;
			end
			drain_pipeline();
		end

		repeat (2 * ROUNDS + 16) @(posedge clk);
		if (pending_blocks.size() != 0) begin
			note_fail($sformatf("%0d results never arrived", pending_blocks.size()));
		end
		if (fail_count == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

FILE: sim.f
rtl/core/xtea_pkg.sv
rtl/core/xtea_in_if.sv
rtl/core/xtea_out_if.sv
rtl/core/xtea_block_cipher.sv
rtl/core/xtea_checker.sv
bench/tb.sv
